### rtl/mufe_pkg.sv
package mufe_pkg;

    localparam int MAX_WORDS_DEF = 16;
    localparam int FRAME_BYTES   = 8;
    localparam int CFG_IDX_W     = 8;

    localparam logic [7:0] HDR_BYTE = 8'h7D;
    localparam logic [7:0] CKS_BIAS = 8'h33;

    typedef enum logic [1:0] {
        MODE_WRITE = 2'd0,
        MODE_READ  = 2'd1,
        MODE_BCAST = 2'd2,
        MODE_RX    = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        KIND_TX   = 2'd0,
        KIND_DATA = 2'd1,
        KIND_DONE = 2'd2
    } t_kind;

    localparam logic [CFG_IDX_W-1:0] CFG_SLAVE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_READ  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_BCAST = CFG_IDX_W'(3);

    typedef struct packed {
        logic [1:0] slave_address;
        logic [1:0] write_code;
        logic [1:0] read_code;
        logic [1:0] broadcast_code;
    } t_cfg;

    typedef struct packed {
        logic [FRAME_BYTES-1:0][7:0] bytes;
        logic [3:0]                  count;
        t_kind                       kind;
        logic                        ok;
    } t_frame;

    function automatic logic [7:0] checksum(input logic [7:0] sum);
        return 8'(~sum + CKS_BIAS);
    endfunction

endpackage

### rtl/meter_uart_frame_engine.sv
// Host-side framer for a half-duplex UART link to a metering chip.
// Each slave-side word carries a request (write, read or broadcast) or a
// byte received from the chip, selected by tuser. Requests produce a command
// frame on the master side, one byte per word, with tlast on the final byte:
// eight bytes for write and broadcast, four for read. Received bytes produce
// at most one word each: a read data byte, or a completion word that carries
// the checksum byte and the check result. A new request drops any reply that
// is still pending.
// An accepted slave word passes the input register, then the serializer
// register, before its first master word. The serializer shifts out one byte
// per cycle while the receiver is ready, so a request holds it for its frame
// and a received byte for one word; a slave word is taken in every cycle that
// it can reload, and one more waits in the input register while it drains.
// When the receiver stalls, the current word holds and the input register
// fills, after which tready drops. Reset (synchronous, active low) empties
// both stages, returns the link state to idle and restores the register
// defaults. The configuration channel is always ready.
module meter_uart_frame_engine #(
    parameter int MAX_WORDS = mufe_pkg::MAX_WORDS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // reg_addr[6:0], data_word[38:7], word_count[43:39], rx_byte[51:44]
    input  logic [55:0]                   s_axis_tdata,
    // mode[1:0]
    input  logic [1:0]                    s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // byte_value[7:0], check_ok[8]
    output logic [15:0]                   m_axis_tdata,
    // kind[1:0]
    output logic [1:0]                    m_axis_tuser,
    output logic                          m_axis_tlast,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [mufe_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [1:0]                    i_cfg_data
);

    mufe_pkg::t_cfg   r_cfg;
    mufe_pkg::t_frame frame;

    logic        r_in_valid;
    logic [1:0]  r_in_mode;
    logic [51:0] r_in_data;
    logic        can_load;
    logic        load;
    logic        out_ok;
    logic [7:0]  out_byte;

    assign o_cfg_ready   = 1'b1;
    assign load          = r_in_valid && can_load;
    assign s_axis_tready = !r_in_valid || load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.slave_address  <= 2'd0;
            r_cfg.write_code     <= 2'd2;
            r_cfg.read_code      <= 2'd1;
            r_cfg.broadcast_code <= 2'd3;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                mufe_pkg::CFG_SLAVE: r_cfg.slave_address  <= i_cfg_data;
                mufe_pkg::CFG_WRITE: r_cfg.write_code     <= i_cfg_data;
                mufe_pkg::CFG_READ:  r_cfg.read_code      <= i_cfg_data;
                mufe_pkg::CFG_BCAST: r_cfg.broadcast_code <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (load) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_mode <= s_axis_tuser;
            r_in_data <= s_axis_tdata[51:0];
        end
    end

    mufe_frame_build #(
        .MAX_WORDS(MAX_WORDS)
    ) u_build (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (load),
        .i_cfg       (r_cfg),
        .i_mode      (r_in_mode),
        .i_reg_addr  (r_in_data[6:0]),
        .i_data_word (r_in_data[38:7]),
        .i_word_count(r_in_data[43:39]),
        .i_rx_byte   (r_in_data[51:44]),
        .o_frame     (frame)
    );

    mufe_serializer u_ser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (load),
        .i_frame   (frame),
        .o_can_load(can_load),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_kind    (m_axis_tuser),
        .o_byte    (out_byte),
        .o_last    (m_axis_tlast),
        .o_ok      (out_ok)
    );

    assign m_axis_tdata = {7'd0, out_ok, out_byte};

endmodule

### rtl/mufe_frame_build.sv
module mufe_frame_build #(
    parameter int MAX_WORDS = mufe_pkg::MAX_WORDS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  mufe_pkg::t_cfg   i_cfg,
    input  logic [1:0]       i_mode,
    input  logic [6:0]       i_reg_addr,
    input  logic [31:0]      i_data_word,
    input  logic [4:0]       i_word_count,
    input  logic [7:0]       i_rx_byte,
    output mufe_pkg::t_frame o_frame
);

    typedef enum logic [2:0] {
        PH_IDLE  = 3'b001,
        PH_WECHO = 3'b010,
        PH_RDATA = 3'b100
    } t_phase;

    t_phase     r_phase, n_phase;
    logic [6:0] r_expected, n_expected;
    logic [6:0] r_seen, n_seen;
    logic [7:0] r_sum, n_sum;
    logic [7:0] r_sent, n_sent;

    logic [4:0] words;
    logic [7:0] cmd_byte;
    logic [7:0] wr_sum;
    logic [7:0] wr_cks;
    logic [7:0] rd_sum;
    logic [1:0] op_code;
    logic       more_data;

    always_comb begin
        if (i_word_count == 5'd0) begin
            words = 5'd1;
        end else if (i_word_count > 5'(MAX_WORDS)) begin
            words = 5'(MAX_WORDS);
        end else begin
            words = i_word_count;
        end
    end

    assign op_code = (mufe_pkg::t_mode'(i_mode) == mufe_pkg::MODE_WRITE) ? i_cfg.write_code
                   : (mufe_pkg::t_mode'(i_mode) == mufe_pkg::MODE_READ) ? i_cfg.read_code
                   : i_cfg.broadcast_code;

    assign cmd_byte = (mufe_pkg::t_mode'(i_mode) == mufe_pkg::MODE_READ)
                    ? {4'(words - 5'd1), i_cfg.slave_address, op_code}
                    : {4'd0, i_cfg.slave_address, op_code};

    assign wr_sum = 8'(cmd_byte + {1'b0, i_reg_addr} + i_data_word[7:0] + i_data_word[15:8]
                    + i_data_word[23:16] + i_data_word[31:24]);
    assign wr_cks = mufe_pkg::checksum(wr_sum);
    assign rd_sum = 8'(cmd_byte + {1'b0, i_reg_addr});

    assign more_data = ({1'b0, r_seen} + 8'd1) < {1'b0, r_expected};

    always_comb begin
        n_phase    = r_phase;
        n_expected = r_expected;
        n_seen     = r_seen;
        n_sum      = r_sum;
        n_sent     = r_sent;
        o_frame       = '0;
        o_frame.kind  = mufe_pkg::KIND_TX;
        unique case (mufe_pkg::t_mode'(i_mode)) inside
            mufe_pkg::MODE_WRITE, mufe_pkg::MODE_BCAST: begin
                o_frame.bytes = {wr_cks, i_data_word, 1'b0, i_reg_addr, cmd_byte,
                                 mufe_pkg::HDR_BYTE};
                o_frame.count = 4'd8;
                n_seen = '0;
                n_sum  = '0;
                if (mufe_pkg::t_mode'(i_mode) == mufe_pkg::MODE_WRITE) begin
                    n_phase    = PH_WECHO;
                    n_expected = 7'd1;
                    n_sent     = wr_cks;
                end else begin
                    n_phase    = PH_IDLE;
                    n_expected = '0;
                end
            end
            mufe_pkg::MODE_READ: begin
                o_frame.bytes[0] = mufe_pkg::HDR_BYTE;
                o_frame.bytes[1] = cmd_byte;
                o_frame.bytes[2] = {1'b0, i_reg_addr};
                o_frame.bytes[3] = mufe_pkg::checksum(rd_sum);
                o_frame.count    = 4'd4;
                n_phase    = PH_RDATA;
                n_expected = {words, 2'b01};
                n_seen     = '0;
                n_sum      = rd_sum;
            end
            default: begin
                o_frame.bytes[0] = i_rx_byte;
                unique case (r_phase)
                    PH_WECHO: begin
                        o_frame.count = 4'd1;
                        o_frame.kind  = mufe_pkg::KIND_DONE;
                        o_frame.ok    = (i_rx_byte == r_sent);
                        n_phase = PH_IDLE;
                        n_seen  = '0;
                    end
                    PH_RDATA: begin
                        o_frame.count = 4'd1;
                        if (more_data) begin
                            o_frame.kind = mufe_pkg::KIND_DATA;
                            n_sum  = 8'(r_sum + i_rx_byte);
                            n_seen = 7'(r_seen + 7'd1);
                        end else begin
                            o_frame.kind = mufe_pkg::KIND_DONE;
                            o_frame.ok   = (i_rx_byte == mufe_pkg::checksum(r_sum));
                            n_phase = PH_IDLE;
                            n_seen  = '0;
                        end
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_expected <= '0;
            r_seen     <= '0;
            r_sum      <= '0;
            r_sent     <= '0;
        end else if (i_load) begin
            r_phase    <= n_phase;
            r_expected <= n_expected;
            r_seen     <= n_seen;
            r_sum      <= n_sum;
            r_sent     <= n_sent;
        end
    end

endmodule

### rtl/mufe_serializer.sv
module mufe_serializer (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  mufe_pkg::t_frame i_frame,
    output logic             o_can_load,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [1:0]       o_kind,
    output logic [7:0]       o_byte,
    output logic             o_last,
    output logic             o_ok
);

    logic [mufe_pkg::FRAME_BYTES-1:0][7:0] r_bytes;
    logic [3:0]                            r_left;
    mufe_pkg::t_kind                       r_kind;
    logic                                  r_ok;

    assign o_valid    = (r_left != 4'd0);
    assign o_can_load = (r_left == 4'd0) || ((r_left == 4'd1) && i_ready);
    assign o_kind     = r_kind;
    assign o_byte     = r_bytes[0];
    assign o_ok       = r_ok;
    assign o_last     = (r_kind == mufe_pkg::KIND_TX) && (r_left == 4'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else if (i_load) begin
            r_left <= i_frame.count;
        end else if (o_valid && i_ready) begin
            r_left <= r_left - 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bytes <= i_frame.bytes;
            r_kind  <= i_frame.kind;
            r_ok    <= i_frame.ok;
        end else if (o_valid && i_ready) begin
            r_bytes <= {8'h00, r_bytes[mufe_pkg::FRAME_BYTES-1:1]};
        end
    end

endmodule

### rtl/mufe_checker.sv
module mufe_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic [55:0]                   s_axis_tdata,
    input logic [1:0]                    s_axis_tuser,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [15:0]                   m_axis_tdata,
    input logic [1:0]                    m_axis_tuser,
    input logic                          m_axis_tlast,
    input logic                          i_cfg_valid,
    input logic                          o_cfg_ready,
    input logic [mufe_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input logic [1:0]                    i_cfg_data
);

    // A framed byte must never be followed by a reply word before tlast.
    a_tx_frame_complete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tuser == mufe_pkg::KIND_TX
        && !m_axis_tlast |=> m_axis_tvalid && m_axis_tuser == mufe_pkg::KIND_TX)
        else $error("transmit frame interrupted before its last byte");

    a_last_only_tx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser == mufe_pkg::KIND_TX)
        else $error("tlast on a reply word");

    a_ok_only_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[8] |-> m_axis_tuser == mufe_pkg::KIND_DONE)
        else $error("check flag set on a word that is not a completion");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("master word changed while stalled");

endmodule

bind meter_uart_frame_engine mufe_checker u_mufe_checker (.*);
